// ===== rtl/core/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types and constants for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd4;

  // Register widths and reset values
  localparam int ITER_W  = 16;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int GREY_W  = 8;

  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd100;
  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd477815112;
  localparam logic signed [COORD_W-1:0] Y_TOP_RST    = 32'sd257966474;
  localparam logic [STEP_W-1:0]         STEP_X_RST   = 31'd671089;
  localparam logic [STEP_W-1:0]         STEP_Y_RST   = 31'd671788;

  // Grey scale factor
  localparam int GREY_SCALE = 255;
  // n*255 fits in this many bits
  localparam int PROD_W = ITER_W + GREY_W;

  // Image mapping configuration
  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_top;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
  } mep_map_t;

  // Point c in the complex plane, Q4.28 register format
  typedef struct packed {
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] a;
  } mep_point_t;

  // Outcome of one escape run
  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              escaped;
  } mep_result_t;

endpackage

// ===== rtl/core/mep_front.sv =====
// ----------------------------------------------------------------------------
// mep_front
// Maps a pixel index pair onto the point c, saturated to the register range.
// ----------------------------------------------------------------------------
module mep_front import mep_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mep_map_t              map,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] column,
  input  logic [INDEX_BITS-1:0] row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mep_point_t            out_point
);

  localparam int PXW = INDEX_BITS + STEP_W;  // index times step
  localparam int SW  = PXW + 2;              // signed sum with headroom

  logic           s1_v_r, s2_v_r;
  logic [PXW-1:0] px_r, py_r;
  mep_point_t     pt_r;
  logic           s1_ready, s2_ready;

  logic signed [SW-1:0] sum_x, sum_y;
  mep_point_t           pt_nxt;

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Offsets from the image edges
  assign sum_x = {{(SW-COORD_W){map.x_origin[COORD_W-1]}}, map.x_origin}
               + $signed({2'b00, px_r});
  assign sum_y = {{(SW-COORD_W){map.y_top[COORD_W-1]}}, map.y_top}
               - $signed({2'b00, py_r});

  // Saturate to 32-bit signed
  always_comb begin
    if (&sum_x[SW-1:COORD_W-1] || ~|sum_x[SW-1:COORD_W-1]) begin
      pt_nxt.a = sum_x[COORD_W-1:0];
    end else begin
      pt_nxt.a = sum_x[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (&sum_y[SW-1:COORD_W-1] || ~|sum_y[SW-1:COORD_W-1]) begin
      pt_nxt.b = sum_y[COORD_W-1:0];
    end else begin
      pt_nxt.b = sum_y[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  // Stage payloads: products, then saturated sums
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      px_r <= column * map.step_x;
      py_r <= row * map.step_y;
    end
    if (s2_ready && s1_v_r) begin
      pt_r <= pt_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_point = pt_r;

endmodule

// ===== rtl/core/mep_fifo.sv =====
// ----------------------------------------------------------------------------
// mep_fifo
// Small register queue between the point mapper and the iteration engine.
// ----------------------------------------------------------------------------
module mep_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

endmodule

// ===== rtl/core/mep_iter.sv =====
// ----------------------------------------------------------------------------
// mep_iter
// Escape-time iteration z = z^2 + c, one step per cycle on three multipliers.
// ----------------------------------------------------------------------------
module mep_iter import mep_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ITER_W-1:0] max_iter,
  input  logic              in_valid,
  output logic              in_ready,
  input  mep_point_t        in_point,
  output logic              res_valid,
  input  logic              res_ready,
  output mep_result_t       res
);

  // z width: holds c plus the bounded square terms
  localparam int ZW = ((FRAC_BITS + 4 > COORD_W) ? FRAC_BITS + 4 : COORD_W) + 1;
  localparam int MW = 2 * ZW;             // raw product
  localparam int PW = MW - FRAC_BITS;     // scaled square, unsigned
  localparam logic [PW:0] FOUR = (PW + 1)'(1) << (FRAC_BITS + 2);

  typedef enum logic [2:0] {
    IT_IDLE = 3'b001,
    IT_RUN  = 3'b010,
    IT_DONE = 3'b100
  } it_state_t;

  it_state_t            state_r, state_nxt;
  logic [PW-1:0]        xx_r, yy_r;     // x*x and y*y of current z
  logic signed [ZW-1:0] xy_r;           // (2x)*y of current z
  logic signed [ZW-1:0] a_r, b_r;
  logic [ITER_W-1:0]    n_r;
  logic                 pend_r;         // products hold a value to test
  mep_result_t          res_r;

  logic signed [ZW-1:0] nx, ny;
  logic signed [MW-1:0] pxx, pyy, pxy;
  logic [PW:0]          mag2;
  logic                 esc_hit, lim_hit;
  logic [ITER_W-1:0]    n_cand;

  // Next z from the stored products
  assign nx = $signed(xx_r[ZW-1:0]) - $signed(yy_r[ZW-1:0]) + a_r;
  assign ny = xy_r + b_r;

  assign pxx = nx * nx;
  assign pyy = ny * ny;
  assign pxy = nx * ny;

  // Escape and limit tests
  assign mag2    = {1'b0, xx_r} + {1'b0, yy_r};
  assign esc_hit = pend_r && (mag2 > FOUR);
  assign n_cand  = pend_r ? n_r + 1'b1 : n_r;
  assign lim_hit = (n_cand == max_iter);

  assign in_ready  = (state_r == IT_IDLE);
  assign res_valid = (state_r == IT_DONE);
  assign res       = res_r;

  // Control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      IT_IDLE: if (in_valid) state_nxt = IT_RUN;
      IT_RUN:  if (esc_hit || lim_hit) state_nxt = IT_DONE;
      IT_DONE: if (res_ready) state_nxt = IT_IDLE;
      default: state_nxt = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IT_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == IT_IDLE) pend_r <= 1'b0;
      else if (state_r == IT_RUN) pend_r <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == IT_IDLE && in_valid) begin
      a_r  <= {{(ZW-COORD_W){in_point.a[COORD_W-1]}}, in_point.a};
      b_r  <= {{(ZW-COORD_W){in_point.b[COORD_W-1]}}, in_point.b};
      xx_r <= '0;
      yy_r <= '0;
      xy_r <= '0;
      n_r  <= '0;
    end else if (state_r == IT_RUN) begin
      if (esc_hit) begin
        res_r.iterations <= n_r;
        res_r.escaped    <= 1'b1;
      end else if (lim_hit) begin
        res_r.iterations <= n_cand;
        res_r.escaped    <= 1'b0;
      end else begin
        xx_r <= pxx[MW-1:FRAC_BITS];
        yy_r <= pyy[MW-1:FRAC_BITS];
        // (2x)*y scaled equals x*y shifted by one bit less
        xy_r <= pxy[FRAC_BITS+ZW-2:FRAC_BITS-1];
        n_r  <= n_cand;
      end
    end
  end

endmodule

// ===== rtl/core/mep_grey.sv =====
// ----------------------------------------------------------------------------
// mep_grey
// Grey byte floor(n*255/max_iter) by restoring division, one bit per cycle,
// and the result output register.
// ----------------------------------------------------------------------------
module mep_grey import mep_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ITER_W-1:0]       max_iter,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mep_result_t             in_res,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [GREY_W-1:0]       grey_level,
  output mep_result_t             out_res
);

  localparam int DSW = ITER_W + GREY_W - 1;  // divisor shifted to top bit
  localparam int BW  = $clog2(GREY_W);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_OUT  = 3'b100
  } dv_state_t;

  dv_state_t         state_r, state_nxt;
  logic [PROD_W-1:0] rem_r;
  logic [DSW-1:0]    dsr_r;
  logic [GREY_W-1:0] quot_r;
  logic [BW-1:0]     bit_r;
  mep_result_t       res_r;

  logic [PROD_W:0]   diff;
  logic              take;
  logic [PROD_W-1:0] scaled;

  // n*255 as n*256 - n
  assign scaled = {in_res.iterations, {GREY_W{1'b0}}} - PROD_W'(in_res.iterations);

  assign diff = {1'b0, rem_r} - {2'b00, dsr_r};
  assign take = !diff[PROD_W];

  assign in_ready   = (state_r == DV_IDLE);
  assign out_valid  = (state_r == DV_OUT);
  assign grey_level = quot_r;
  assign out_res    = res_r;

  // Control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (in_valid) state_nxt = (in_res.iterations == '0) ? DV_OUT : DV_RUN;
      DV_RUN:  if (bit_r == '0) state_nxt = DV_OUT;
      DV_OUT:  if (out_ready) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider datapath; quotient never exceeds 255 since n <= max_iter
  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && in_valid) begin
      res_r  <= in_res;
      rem_r  <= scaled;
      dsr_r  <= {max_iter, {(GREY_W-1){1'b0}}};
      quot_r <= '0;
      bit_r  <= BW'(GREY_W - 1);
    end else if (state_r == DV_RUN) begin
      if (take) rem_r <= diff[PROD_W-1:0];
      dsr_r  <= dsr_r >> 1;
      quot_r <= {quot_r[GREY_W-2:0], take};
      bit_r  <= bit_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/mandelbrot_escape_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// Escape-time evaluator for one pixel per transfer on a stream channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : pixel transfers, tdata = {row, column}, column in the low bits.
//   out_*  : one result transfer per pixel, tdata = {iterations, grey_level},
//            tuser = escaped.
//   cfg_*  : register writes (0 max_iter, 1 x_origin, 2 y_top, 3 step_x,
//            4 step_y); always ready, write only while the block is idle.
// Path: point mapping (products, then saturated sums), the queue, iteration
//   of z until escape or the limit, handoff to the divider, then restoring
//   division into the output register.
// Pixel rate: set by the single iteration datapath (three multipliers, one z
//   update per cycle), which takes a new point only after handing off its last
//   result, and by the divider; division overlaps the next iteration.
// Reset: configuration returns to its default view, all queues empty.
// Stall: a waiting result holds the divider, then the iteration engine; the
//   queue and mapper keep taking pixels until they are full.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top import mep_pkg::*; #(
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input: column [INDEX_BITS-1:0], row [2*INDEX_BITS-1:INDEX_BITS]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((2*INDEX_BITS+7)/8)*8-1:0]   in_tdata,
  // result: grey_level [7:0], iterations [23:8]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,
  // result flag: escaped [0]
  output logic [0:0]                          out_tuser,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  logic [ITER_W-1:0] max_iter_r;
  mep_map_t          map_r;

  logic              fr_valid, fr_ready;
  mep_point_t        fr_point;
  logic              q_valid, q_ready;
  logic [$bits(mep_point_t)-1:0] q_data;
  mep_point_t        q_point;
  logic              it_valid, it_ready;
  mep_result_t       it_res;
  logic [GREY_W-1:0] grey;
  mep_result_t       out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r     <= MAX_ITER_RST;
      map_r.x_origin <= X_ORIGIN_RST;
      map_r.y_top    <= Y_TOP_RST;
      map_r.step_x   <= STEP_X_RST;
      map_r.step_y   <= STEP_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER: max_iter_r     <= cfg_data[ITER_W-1:0];
        REG_X_ORIGIN: map_r.x_origin <= cfg_data[COORD_W-1:0];
        REG_Y_TOP:    map_r.y_top    <= cfg_data[COORD_W-1:0];
        REG_STEP_X:   map_r.step_x   <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:   map_r.step_y   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Point mapping
  mep_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .map       (map_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .column    (in_tdata[INDEX_BITS-1:0]),
    .row       (in_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_point (fr_point)
  );

  // Queue between mapping and iteration
  mep_fifo #(
    .WIDTH ($bits(mep_point_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_point),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign q_point = q_data;

  // Escape iteration
  mep_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_iter  (max_iter_r),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_point  (q_point),
    .res_valid (it_valid),
    .res_ready (it_ready),
    .res       (it_res)
  );

  // Grey level and output register
  mep_grey u_grey (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_iter   (max_iter_r),
    .in_valid   (it_valid),
    .in_ready   (it_ready),
    .in_res     (it_res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .grey_level (grey),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.iterations, grey};
  assign out_tuser = out_res.escaped;

endmodule
